// File: hw/rtl/vang_pkg.sv
package vang_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_COORD_WIDTH     = 16;
    localparam int DEF_ANGLE_FRAC_BITS = 13;

    // CORDIC datapath: magnitudes are scaled so the largest is 2^60.
    localparam int CORDIC_STEPS = 32;
    localparam int CORDIC_WIDTH = 64;
    localparam int CORDIC_TOP   = 61;
    // Angle accumulator in binary units, 2^32 units per turn.
    localparam int Z_WIDTH      = 33;
    localparam int UNIT_WIDTH   = 33;
    localparam int TQ_WIDTH     = 31;

    localparam logic [UNIT_WIDTH-1:0] QUARTER_TURN = 33'h0_4000_0000;
    localparam logic [31:0]           PI_Q30       = 32'hC90F_DAA2;

    localparam logic [31:0] ATAN_UNITS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Quadrant and axis information that rides along with the CORDIC stages.
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic ax_zero;
        logic ay_zero;
    } vang_flags_t;

endpackage

// File: hw/rtl/vector_angle_top.sv
// Channel  | Valid      | Stall      | Fields
// ---------+------------+------------+------------------------------
// input    | in_valid   | in_stall   | coord_x, coord_y (signed)
// output   | out_valid  | out_stall  | angle_rad (unsigned Q3.F rad)
//
// One word is accepted per clock cycle unless in_stall is high; each word
// passes through one CORDIC rotation per stage plus the input scaling,
// the quadrant fix, a two-part multiply, rounding and the final wrap.
// Reset clears only the valid bits; no clearing pass is needed.
// A stall on the output freezes the whole pipeline while the output word
// waits, and in_stall follows it in the same cycle.
module vector_angle_top #(
    parameter int COORD_WIDTH     = vang_pkg::DEF_COORD_WIDTH,
    parameter int ANGLE_FRAC_BITS = vang_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ANGLE_FRAC_BITS+2:0]   angle_rad
);
    import vang_pkg::*;

    localparam int AW        = ANGLE_FRAC_BITS + 3;
    localparam int PRE_SHIFT = CORDIC_TOP - COORD_WIDTH;
    localparam int RES_SHIFT = CORDIC_TOP - ANGLE_FRAC_BITS;
    localparam logic [63:0] ROUND_ADD = 64'd1 << (RES_SHIFT - 1);
    localparam logic [63:0] FULL_PROD = {PI_Q30, 32'd0};
    localparam logic [63:0] FULL_WIDE = (FULL_PROD + ROUND_ADD) >> RES_SHIFT;
    localparam logic [AW-1:0] FULL_ANGLE = FULL_WIDE[AW-1:0];

    // Stage numbering: 0 scale, 1..STEPS rotate, then quadrant, two
    // multiply stages, round, wrap.
    localparam int ST_OUT  = CORDIC_STEPS + 5;
    localparam int LAT     = CORDIC_STEPS + 6;

    logic advance;
    logic vld_reg [0:LAT-1];

    logic signed [CORDIC_WIDTH-1:0] cx_reg [0:CORDIC_STEPS];
    logic signed [CORDIC_WIDTH-1:0] cy_reg [0:CORDIC_STEPS];
    logic signed [Z_WIDTH-1:0]      z_reg  [0:CORDIC_STEPS];
    vang_flags_t                    flags_reg [0:CORDIC_STEPS];

    logic [COORD_WIDTH-1:0] ax_next;
    logic [COORD_WIDTH-1:0] ay_next;
    vang_flags_t            flags_next;

    logic [TQ_WIDTH-1:0]   tq_next;
    logic [UNIT_WIDTH-1:0] a_next;
    logic [UNIT_WIDTH-1:0] a_reg;

    logic [47:0] p_lo_next;
    logic [47:0] p_lo_reg;
    logic [47:0] p_lo2_reg;
    logic [16:0] a_hi_reg;
    logic [48:0] p_hi_next;
    logic [48:0] p_hi_reg;

    logic [63:0]   sum_next;
    logic [AW-1:0] r_next;
    logic [AW-1:0] r_reg;
    logic [AW-1:0] angle_next;
    logic [AW-1:0] angle_reg;

    // The pipeline moves unless a finished word is held at the output.
    assign advance   = !(vld_reg[ST_OUT] && out_stall);
    assign in_stall  = !advance;
    assign out_valid = vld_reg[ST_OUT];
    assign angle_rad = angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Stage 0: magnitudes, scaled to the top of the CORDIC word.
    always_comb
    begin
        ax_next            = coord_x[COORD_WIDTH-1] ? COORD_WIDTH'(-coord_x) : coord_x;
        ay_next            = coord_y[COORD_WIDTH-1] ? COORD_WIDTH'(-coord_y) : coord_y;
        flags_next.x_neg   = coord_x[COORD_WIDTH-1];
        flags_next.y_neg   = coord_y[COORD_WIDTH-1];
        flags_next.ax_zero = (coord_x == '0);
        flags_next.ay_zero = (coord_y == '0);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cx_reg[0]    <= signed'(CORDIC_WIDTH'(ax_next) << PRE_SHIFT);
            cy_reg[0]    <= signed'(CORDIC_WIDTH'(ay_next) << PRE_SHIFT);
            z_reg[0]     <= '0;
            flags_reg[0] <= flags_next;
        end
    end

    // One vectoring rotation per stage; >>> gives the floor shift.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        localparam logic signed [Z_WIDTH-1:0] ATAN_I = signed'(Z_WIDTH'(ATAN_UNITS[i]));

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                if (!cy_reg[i][CORDIC_WIDTH-1])
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    z_reg[i+1]  <= z_reg[i] + ATAN_I;
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    z_reg[i+1]  <= z_reg[i] - ATAN_I;
                end
                flags_reg[i+1] <= flags_reg[i];
            end
        end
    end

    // Quadrant stage: clamp the first-quadrant angle, handle the axes,
    // then unfold into the full turn.
    always_comb
    begin
        if (flags_reg[CORDIC_STEPS].ay_zero)
        begin
            tq_next = '0;
        end
        else if (flags_reg[CORDIC_STEPS].ax_zero)
        begin
            tq_next = TQ_WIDTH'(QUARTER_TURN);
        end
        else if (z_reg[CORDIC_STEPS][Z_WIDTH-1])
        begin
            tq_next = '0;
        end
        else if (z_reg[CORDIC_STEPS] > signed'(Z_WIDTH'(QUARTER_TURN)))
        begin
            tq_next = TQ_WIDTH'(QUARTER_TURN);
        end
        else
        begin
            tq_next = z_reg[CORDIC_STEPS][TQ_WIDTH-1:0];
        end

        case ({flags_reg[CORDIC_STEPS].x_neg, flags_reg[CORDIC_STEPS].y_neg})
            2'b00:   a_next = UNIT_WIDTH'(tq_next);
            2'b10:   a_next = (QUARTER_TURN << 1) - UNIT_WIDTH'(tq_next);
            2'b11:   a_next = (QUARTER_TURN << 1) + UNIT_WIDTH'(tq_next);
            default: a_next = (QUARTER_TURN << 2) - UNIT_WIDTH'(tq_next);
        endcase
    end

    // Units to radians: a * pi*2^30 split into a low and a high partial product.
    assign p_lo_next = 48'(a_reg[15:0]) * 48'(PI_Q30);
    assign p_hi_next = 49'(a_hi_reg) * 49'(PI_Q30);
    assign sum_next  = 64'({p_hi_reg, 16'd0}) + 64'(p_lo2_reg) + ROUND_ADD;
    assign r_next    = AW'(sum_next >> RES_SHIFT);
    assign angle_next = (r_reg >= FULL_ANGLE) ? (r_reg - FULL_ANGLE) : r_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg     <= a_next;
            p_lo_reg  <= p_lo_next;
            a_hi_reg  <= a_reg[UNIT_WIDTH-1:16];
            p_hi_reg  <= p_hi_next;
            p_lo2_reg <= p_lo_reg;
            r_reg     <= r_next;
            angle_reg <= angle_next;
        end
    end

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = vang_pkg::DEF_COORD_WIDTH;
    localparam int AF = vang_pkg::DEF_ANGLE_FRAC_BITS;
    localparam int AW = AF + 3;
    localparam int PIPE_DEPTH = vang_pkg::CORDIC_STEPS + 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_PRINTED = 100;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [AW-1:0]        angle;
    } angle_word_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [CW-1:0] coord_x = '0;
    logic signed [CW-1:0] coord_y = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [AW-1:0]        angle_rad;

    angle_word_t pending_angles[$];
    angle_word_t oldest;
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    vector_angle_top #(
        .COORD_WIDTH    (CW),
        .ANGLE_FRAC_BITS(AF)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .coord_x  (coord_x),
        .coord_y  (coord_y),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .angle_rad(angle_rad)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Four-quadrant arctangent: CORDIC vectoring on the magnitudes in binary
    // angle units (2^32 per turn), quadrant restore, then rounding to radians.
    function automatic logic [AW-1:0] polar_angle(logic signed [CW-1:0] x,
                                                  logic signed [CW-1:0] y);
        longint      sx;
        longint      sy;
        longint      cx;
        longint      cy;
        longint      dx;
        longint      dy;
        longint      z;
        longint      qt;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] turn;
        logic [63:0] rad;
        logic [63:0] full;
        logic [63:0] half_lsb;
        sx = longint'(x);
        sy = longint'(y);
        qt = longint'(vang_pkg::QUARTER_TURN);
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        z = 0;
        if (ay == 0)
        begin
            z = 0;
        end
        else if (ax == 0)
        begin
            z = qt;
        end
        else
        begin
            cx = ax << (61 - CW);
            cy = ay << (61 - CW);
            for (int i = 0; i < vang_pkg::CORDIC_STEPS; i++)
            begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0)
                begin
                    cx = cx + dx;
                    cy = cy - dy;
                    z = z + longint'(vang_pkg::ATAN_UNITS[i]);
                end
                else
                begin
                    cx = cx - dx;
                    cy = cy + dy;
                    z = z - longint'(vang_pkg::ATAN_UNITS[i]);
                end
            end
            if (z < 0)
                z = 0;
            if (z > qt)
                z = qt;
        end
        if (sx >= 0 && sy >= 0)
            turn = z;
        else if (sx < 0 && sy >= 0)
            turn = 2 * qt - z;
        else if (sx < 0)
            turn = 2 * qt + z;
        else
            turn = 4 * qt - z;
        half_lsb = 64'd1 << (60 - AF);
        rad = (turn * 64'(vang_pkg::PI_Q30) + half_lsb) >> (61 - AF);
        full = ((4 * 64'(qt)) * 64'(vang_pkg::PI_Q30) + half_lsb) >> (61 - AF);
        // An angle that rounds up to a full turn wraps to zero.
        if (rad >= full)
            rad = rad - full;
        return rad[AW-1:0];
    endfunction

    // Half full-range values, with small magnitudes and the edge values
    // mixed in so that vectors near the axes come up often.
    function automatic logic signed [CW-1:0] random_coord();
        int unsigned shape;
        shape = $urandom_range(11);
        if (shape < 6)
            return CW'($urandom);
        if (shape < 9)
            return CW'($urandom_range(16) - 8);
        case ($urandom_range(4))
            0: return {1'b1, {(CW - 1){1'b0}}};
            1: return {1'b0, {(CW - 1){1'b1}}};
            2: return '0;
            3: return CW'(1);
            default: return '1;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Called and returns at a falling edge; valid is left high after the word
    // is taken so that back-to-back words need no gap.
    task automatic send_word(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
        angle_word_t w;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        coord_x <= x;
        coord_y <= y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        w.x = x;
        w.y = y;
        w.angle = polar_angle(x, y);
        pending_angles.push_back(w);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_special_vectors();
        int pts [20][2] = '{
            '{0, 0}, '{1, 0}, '{32767, 0}, '{-1, 0}, '{-32768, 0},
            '{0, 1}, '{0, 32767}, '{0, -1}, '{0, -32768}, '{1, 1},
            '{-1, -1}, '{32767, 32767}, '{-32768, -32768}, '{-32768, 32767},
            '{32767, -32768}, '{32767, -1}, '{-32768, -1}, '{-32768, 1},
            '{1, 32767}, '{-1, -32768}
        };
        send_idle_pct = 0;
        stall_pct = 0;
        for (int k = 0; k < 20; k++)
            send_word(CW'(pts[k][0]), CW'(pts[k][1]));
    endtask

    // The sender holds off until the pipeline is empty, then resumes.
    task automatic test_drain_pause();
        send_idle_pct = 38;
        stall_pct = 38;
        for (int k = 0; k < 20; k++)
            send_word(random_coord(), random_coord());
        wait_for_results();
        for (int k = 0; k < 20; k++)
            send_word(random_coord(), random_coord());
    endtask

    task automatic test_random_angles(input int idle_pct, input int stall_rate, input int count);
        send_idle_pct = idle_pct;
        stall_pct = stall_rate;
        for (int k = 0; k < count; k++)
            send_word(random_coord(), random_coord());
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_angles.size() == 0)
            begin
                report_mismatch($sformatf("angle_rad %0d with no word pending", angle_rad));
            end
            else
            begin
                oldest = pending_angles.pop_front();
                if (angle_rad !== oldest.angle)
                    report_mismatch($sformatf("x=%0d y=%0d: angle_rad %0d, want %0d",
                                              oldest.x, oldest.y, angle_rad, oldest.angle));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_special_vectors();
        test_drain_pause();
        test_random_angles(0, 0, 420);
        test_random_angles(74, 0, 420);
        test_random_angles(0, 74, 420);
        test_random_angles(38, 38, 420);
        wait_for_results();
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/vang_pkg.sv
hw/rtl/vector_angle_top.sv
tb/tb_top.sv
